FILE: sv/fclm_pkg.sv
// ----------------------------------------------------------------------------
// Fully connected layer MAC package
// Shared transaction types, operation and register codes, and number formats.
// ----------------------------------------------------------------------------
package fclm_pkg;

    localparam int DATA_W = 16;
    localparam int FRAC_W = 8;
    localparam int ACC_W  = 40;
    localparam int IDX_W  = 8;
    localparam int COL_W  = 6;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_ACT    = 2'd2;

    localparam logic [1:0] REG_INPUTS  = 2'd0;
    localparam logic [1:0] REG_OUTPUTS = 2'd1;
    localparam logic [1:0] REG_BIAS_EN = 2'd2;

    typedef struct packed {
        logic [1:0]               operation;
        logic [IDX_W-1:0]         in_index;
        logic [COL_W-1:0]         out_index;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [COL_W-1:0]         result_index;
        logic                     row_last;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     saturated;
    } t_drain;

    typedef struct packed {
        logic weight_we;
        logic bias_we;
        logic bias_en;
        logic stage1;
        logic stage2;
        logic first2;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

FILE: sv/fclm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fclm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/fclm_cell.sv
// ----------------------------------------------------------------------------
// MAC cell
// Holds one weight column, one bias word and one accumulator, and passes
// finished results to its neighbor toward the head of the chain.
// ----------------------------------------------------------------------------
module fclm_cell #(
    parameter int IN_MAX     = 256,
    parameter int CELL_INDEX = 0
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  fclm_pkg::t_cell_ctl                         i_ctl,
    input  logic [fclm_pkg::COL_W-1:0]                  i_col,
    input  logic [(IN_MAX > 1 ? $clog2(IN_MAX) : 1)-1:0] i_wr_addr,
    input  logic [(IN_MAX > 1 ? $clog2(IN_MAX) : 1)-1:0] i_rd_addr,
    input  logic signed [fclm_pkg::DATA_W-1:0]          i_wdata,
    input  logic signed [fclm_pkg::DATA_W-1:0]          i_x,
    input  fclm_pkg::t_drain                            i_next,
    output fclm_pkg::t_drain                            o_out
);

    localparam int DW = fclm_pkg::DATA_W;
    localparam int FW = fclm_pkg::FRAC_W;
    localparam int AW = fclm_pkg::ACC_W;

    logic                   col_hit;
    logic [DW-1:0]          w_rd;
    logic signed [DW-1:0]   r_bias;
    logic signed [2*DW-1:0] r_prod;
    logic signed [DW-1:0]   r_base;
    logic signed [AW-1:0]   r_acc;
    logic signed [AW-1:0]   n_acc;
    logic signed [AW-1:0]   acc_start;
    logic [AW-DW-FW:0]      acc_top;
    logic                   sat;
    logic signed [DW-1:0]   sat_value;
    fclm_pkg::t_drain       r_out;

    assign col_hit = (i_col == fclm_pkg::COL_W'(CELL_INDEX));

    fclm_ram #(
        .WIDTH (DW),
        .DEPTH (IN_MAX)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (i_ctl.weight_we & col_hit),
        .i_waddr (i_wr_addr),
        .i_wdata (i_wdata),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.bias_we && col_hit) begin
            r_bias <= i_wdata;
        end
        if (i_ctl.stage1) begin
            r_prod <= i_x * $signed(w_rd);
            r_base <= i_ctl.bias_en ? r_bias : '0;
        end
    end

    always_comb begin
        acc_start = i_ctl.first2 ? {{(AW-DW-FW){r_base[DW-1]}}, r_base, {FW{1'b0}}} : r_acc;
        n_acc     = acc_start + AW'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.stage2) begin
            r_acc <= n_acc;
        end
    end

    always_comb begin
        acc_top   = r_acc[AW-1:DW+FW-1];
        sat       = !((&acc_top) || !(|acc_top));
        sat_value = r_acc[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_out.result    <= sat ? sat_value : r_acc[DW+FW-1:FW];
            r_out.saturated <= sat;
        end else if (i_ctl.shift) begin
            r_out <= i_next;
        end
    end

    assign o_out = r_out;

endmodule

FILE: sv/fully_connected_layer_mac.sv
// ----------------------------------------------------------------------------
// Fully connected layer MAC engine
// Matrix-vector multiply with optional bias over a chain of MAC cells, one
// cell per output feature, with saturated Q8.8 results.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// item in   input      start high, busy low      i_item (t_in_item)
// result    output     o_strobe per result       o_item (t_out_item)
// config    input      APB write, pready high    paddr, pwdata, prdata
//
// Weight and bias loads and every element but the last of a row leave busy
// low, so a new item can follow at once. The last element of a row holds
// busy through the weight RAM read, multiply, accumulate and load stages,
// then while the cell chain shifts out one result per cycle. Reset sets
// the registers to their defaults and the row position to zero; weight and
// bias contents are undefined until loaded. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module fully_connected_layer_mac #(
    parameter int IN_MAX  = 256,
    parameter int OUT_MAX = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  fclm_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output fclm_pkg::t_out_item o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int PW   = IN_MAX > 1 ? $clog2(IN_MAX) : 1;
    localparam int CMPW = (PW + 1 > 10) ? PW + 1 : 10;
    localparam int DW   = fclm_pkg::DATA_W;
    localparam int CW   = fclm_pkg::COL_W;

    logic [8:0]            r_inputs;
    logic [6:0]            r_outputs;
    logic                  r_bias_en;
    logic [1:0]            reg_index;
    logic                  cfg_write;

    logic [PW-1:0]         r_pos;
    logic [CMPW-1:0]       n_in;
    logic [CMPW-1:0]       inputs_wide;
    logic [CMPW-1:0]       pos_next;
    logic [6:0]            n_out;
    logic [CW-1:0]         last_index;
    logic                  row_end;
    logic                  accept;
    logic                  accept_act;
    logic                  in_row_ok;
    logic                  out_col_ok;
    logic [CMPW-1:0]       in_index_wide;

    logic signed [DW-1:0]  r_x;
    logic                  r_v1;
    logic                  r_first1;
    logic                  r_last1;
    logic                  r_v2;
    logic                  r_first2;
    logic                  r_last2;
    logic                  r_load;
    logic                  r_pend;
    logic                  r_draining;
    logic [CW-1:0]         r_cnt;

    fclm_pkg::t_cell_ctl   ctl;
    fclm_pkg::t_drain      chain [OUT_MAX+1];

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inputs  <= 9'd256;
            r_outputs <= 7'd64;
            r_bias_en <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_index)
                fclm_pkg::REG_INPUTS:  r_inputs  <= pwdata[8:0];
                fclm_pkg::REG_OUTPUTS: r_outputs <= pwdata[6:0];
                fclm_pkg::REG_BIAS_EN: r_bias_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            fclm_pkg::REG_INPUTS:  prdata = 32'(r_inputs);
            fclm_pkg::REG_OUTPUTS: prdata = 32'(r_outputs);
            fclm_pkg::REG_BIAS_EN: prdata = 32'(r_bias_en);
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        inputs_wide = CMPW'(r_inputs);
        if (inputs_wide == '0) begin
            n_in = CMPW'(1);
        end else if (inputs_wide > CMPW'(IN_MAX)) begin
            n_in = CMPW'(IN_MAX);
        end else begin
            n_in = inputs_wide;
        end
        if (r_outputs == '0) begin
            n_out = 7'd1;
        end else if (r_outputs > 7'(OUT_MAX)) begin
            n_out = 7'(OUT_MAX);
        end else begin
            n_out = r_outputs;
        end
        last_index    = CW'(n_out - 7'd1);
        pos_next      = CMPW'(r_pos) + CMPW'(1);
        row_end       = (pos_next >= n_in);
        in_index_wide = CMPW'(i_item.in_index);
        in_row_ok     = (in_index_wide < CMPW'(IN_MAX));
        out_col_ok    = (7'(i_item.out_index) < 7'(OUT_MAX));
    end

    assign busy       = r_pend | r_draining;
    assign accept     = start & ~busy;
    assign accept_act = accept && (i_item.operation == fclm_pkg::OP_ACT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_load     <= 1'b0;
            r_pend     <= 1'b0;
            r_draining <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_v1   <= accept_act;
            r_v2   <= r_v1;
            r_load <= r_v2 & r_last2;
            if (accept_act) begin
                r_pos <= row_end ? '0 : pos_next[PW-1:0];
            end
            if (accept_act && row_end) begin
                r_pend <= 1'b1;
            end else if (r_load) begin
                r_pend <= 1'b0;
            end
            if (r_load) begin
                r_draining <= 1'b1;
                r_cnt      <= '0;
            end else if (r_draining) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == last_index) begin
                    r_draining <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_act) begin
            r_x      <= i_item.value;
            r_first1 <= (r_pos == '0);
            r_last1  <= row_end;
        end
        r_first2 <= r_first1;
        r_last2  <= r_last1;
    end

    always_comb begin
        ctl.weight_we = accept && (i_item.operation == fclm_pkg::OP_WEIGHT)
                        && in_row_ok && out_col_ok;
        ctl.bias_we   = accept && (i_item.operation == fclm_pkg::OP_BIAS) && out_col_ok;
        ctl.bias_en   = r_bias_en;
        ctl.stage1    = r_v1;
        ctl.stage2    = r_v2;
        ctl.first2    = r_first2;
        ctl.load      = r_load;
        ctl.shift     = r_draining;
    end

    assign chain[OUT_MAX] = '0;

    for (genvar k = 0; k < OUT_MAX; k++) begin : g_cell
        fclm_cell #(
            .IN_MAX     (IN_MAX),
            .CELL_INDEX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_col     (i_item.out_index),
            .i_wr_addr (in_index_wide[PW-1:0]),
            .i_rd_addr (r_pos),
            .i_wdata   (i_item.value),
            .i_x       (r_x),
            .i_next    (chain[k+1]),
            .o_out     (chain[k])
        );
    end

    assign o_strobe            = r_draining;
    assign o_item.result       = chain[0].result;
    assign o_item.saturated    = chain[0].saturated;
    assign o_item.result_index = r_cnt;
    assign o_item.row_last     = (r_cnt == last_index);

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while the block reports idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_item.row_last) |=> !o_strobe)
        else $error("results continue after the last of a row");

    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_act && row_end) |=> busy)
        else $error("block not busy after the final element of a row");

    a_row_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_act && row_end) |-> ##4 (o_strobe && o_item.result_index == '0))
        else $error("first result of a row not on time");

    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> (o_item.result_index == '0))
        else $error("row results do not start at output zero");

endmodule
